FILE: rtl/core/cordic_pkg.sv
// Shared widths, constants and helper functions for the CORDIC sine/cosine core.
package cordic_pkg;

    localparam int ITERATIONS = 12;
    localparam int TABLE_SIZE = 16;
    localparam int STEPS      = (ITERATIONS > TABLE_SIZE) ? TABLE_SIZE : ITERATIONS;

    localparam int ANGLE_W = 24;
    localparam int Z_W     = 25;
    localparam int XY_W    = 32;
    localparam int FRAC_XY = 30;
    localparam int GAIN_W  = 16;
    localparam int PROD_W  = XY_W + GAIN_W + 1;
    localparam int RND_SH  = 31;
    localparam int Q_W     = PROD_W - RND_SH;
    localparam int OUT_W   = 16;

    localparam int LATENCY = STEPS + 3;

    localparam logic signed [Z_W-1:0]    ANGLE_MAX = Z_W'(5898240);
    localparam logic signed [Z_W-1:0]    ANGLE_MIN = -ANGLE_MAX;
    localparam logic signed [XY_W-1:0]   ONE_XY    = XY_W'(64'sd1 <<< FRAC_XY);
    localparam logic signed [GAIN_W:0]   GAIN_S    = (GAIN_W + 1)'(39793);
    localparam logic signed [PROD_W-1:0] RND_HALF  = PROD_W'(64'sd1 <<< (RND_SH - 1));
    localparam logic signed [Q_W-1:0]    OUT_MAX   = Q_W'(32767);
    localparam logic signed [Q_W-1:0]    OUT_MIN   = -Q_W'(32768);

    typedef logic signed [XY_W-1:0] t_xy;
    typedef logic signed [Z_W-1:0]  t_z;

    function automatic t_z f_step_angle(input int idx);
        t_z a;
        case (idx)
            0:       a = Z_W'(2949120);
            1:       a = Z_W'(1740787);
            2:       a = Z_W'(919581);
            3:       a = Z_W'(467114);
            4:       a = Z_W'(234311);
            5:       a = Z_W'(117152);
            6:       a = Z_W'(58576);
            7:       a = Z_W'(29288);
            8:       a = Z_W'(14647);
            9:       a = Z_W'(7510);
            10:      a = Z_W'(3755);
            11:      a = Z_W'(1874);
            12:      a = Z_W'(937);
            13:      a = Z_W'(472);
            14:      a = Z_W'(236);
            15:      a = Z_W'(118);
            default: a = '0;
        endcase
        return a;
    endfunction

    function automatic logic signed [OUT_W-1:0] f_sat(input logic signed [Q_W-1:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > OUT_MAX) begin
            r = OUT_W'(OUT_MAX);
        end else if (v < OUT_MIN) begin
            r = OUT_W'(OUT_MIN);
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/cordic_sine_cosine_core.sv
// Pipelined CORDIC rotation core giving sine and cosine of an angle in degrees.
// Pipeline: one clamp stage, one stage per micro-rotation, one gain multiply stage and
// one round and saturate stage.
// Throughput: one transaction per cycle; busy stays low and results cannot be stalled.
// Reset: synchronous active-low reset clears all valid bits and the output strobe.
module cordic_sine_cosine_core
    import cordic_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    input  logic signed [ANGLE_W-1:0] i_angle_deg,
    output logic                      busy,
    output logic                      o_strobe,
    output logic signed [OUT_W-1:0]   o_sine_out,
    output logic signed [OUT_W-1:0]   o_cosine_out
);

    t_xy r_x [0:STEPS];
    t_xy r_y [0:STEPS];
    t_z  r_z [0:STEPS];
    logic [STEPS:0] r_vld;

    logic signed [PROD_W-1:0] r_prod_x;
    logic signed [PROD_W-1:0] r_prod_y;
    logic                     r_mul_vld;

    t_z n_z0;
    logic signed [PROD_W-1:0] n_prod_x;
    logic signed [PROD_W-1:0] n_prod_y;
    logic signed [PROD_W-1:0] w_rnd_x;
    logic signed [PROD_W-1:0] w_rnd_y;

    assign busy = 1'b0;

    always_comb begin
        n_z0 = Z_W'(i_angle_deg);
        if (n_z0 > ANGLE_MAX) begin
            n_z0 = ANGLE_MAX;
        end else if (n_z0 < ANGLE_MIN) begin
            n_z0 = ANGLE_MIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= start && !busy;
        end
        r_x[0] <= ONE_XY;
        r_y[0] <= '0;
        r_z[0] <= n_z0;
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_stage
        t_xy w_xs;
        t_xy w_ys;
        assign w_xs = r_x[k] >>> k;
        assign w_ys = r_y[k] >>> k;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
            if (!r_z[k][Z_W-1]) begin
                r_x[k+1] <= r_x[k] - w_ys;
                r_y[k+1] <= r_y[k] + w_xs;
                r_z[k+1] <= r_z[k] - f_step_angle(k);
            end else begin
                r_x[k+1] <= r_x[k] + w_ys;
                r_y[k+1] <= r_y[k] - w_xs;
                r_z[k+1] <= r_z[k] + f_step_angle(k);
            end
        end
    end

    assign n_prod_x = PROD_W'(r_x[STEPS]) * PROD_W'(GAIN_S);
    assign n_prod_y = PROD_W'(r_y[STEPS]) * PROD_W'(GAIN_S);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_vld <= 1'b0;
        end else begin
            r_mul_vld <= r_vld[STEPS];
        end
        r_prod_x <= n_prod_x;
        r_prod_y <= n_prod_y;
    end

    assign w_rnd_x = r_prod_x + RND_HALF;
    assign w_rnd_y = r_prod_y + RND_HALF;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= r_mul_vld;
        end
        o_sine_out   <= f_sat($signed(w_rnd_y[PROD_W-1:RND_SH]));
        o_cosine_out <= f_sat($signed(w_rnd_x[PROD_W-1:RND_SH]));
    end

    a_never_busy: assert property (@(posedge i_clk) !busy)
        else $error("busy raised on a non-stalling pipeline");

    a_clamp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> (r_z[0] <= ANGLE_MAX) && (r_z[0] >= ANGLE_MIN))
        else $error("clamped angle out of range");

    a_strobe_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_vld[STEPS], 2))
        else $error("result strobe without a transaction in the rotation pipeline");

    a_entry_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> r_vld[0])
        else $error("accepted transaction lost at pipeline entry");

endmodule
